>>> rtl/cfpd_pkg.sv
// Shared types and constants for the configuration packet deframer.
// No dependencies; imported by cfpd_parser and fpga_config_packet_deframer.
package cfpd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned AddrW  = 14;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned OpW    = 2;
  localparam int unsigned KindW  = 3;
  localparam int unsigned OutDataW = 88;

  // header type codes
  localparam logic [TypeW-1:0] HT_NOOP  = 3'd0;
  localparam logic [TypeW-1:0] HT_TYPE1 = 3'd1;
  localparam logic [TypeW-1:0] HT_TYPE2 = 3'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DATA   = 3'd1,
    PH_CNT_HI = 3'd2,
    PH_CNT_LO = 3'd3,
    PH_BAD    = 3'd4
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_SKIP  = 3'd0,
    KIND_HDR   = 3'd1,
    KIND_DATA  = 3'd2,
    KIND_BAD   = 3'd3,
    KIND_TRUNC = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [TypeW-1:0]  header_kind;
    logic [OpW-1:0]    operation;
    logic [AddrW-1:0]  reg_address;
    logic [WordW-1:0]  payload_count;
    logic [WordW-1:0]  data;
    logic              last_of_packet;
  } result_t;

endpackage

>>> rtl/cfpd_parser.sv
// Packet parser: phase state machine, packet context and per-word result decode.
// Depends on cfpd_pkg.
module cfpd_parser import cfpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  logic [WordW-1:0] word_i,
  input  logic             end_i,
  input  logic             narrow_i,
  output result_t          res_o
);

  phase_t            phase_r, phase_nxt;
  logic [WordW-1:0]  words_left_r, words_left_nxt;
  logic [TypeW-1:0]  cur_type_r, cur_type_nxt;
  logic [OpW-1:0]    cur_op_r, cur_op_nxt;
  logic [AddrW-1:0]  cur_addr_r, cur_addr_nxt;
  logic [AddrW-1:0]  prev_addr_r, prev_addr_nxt;
  logic              prev_valid_r, prev_valid_nxt;
  logic              drop_r, drop_nxt;

  logic [TypeW-1:0]  hdr_type;
  logic [OpW-1:0]    hdr_op;
  logic [AddrW-1:0]  hdr_addr;
  logic [WordW-1:0]  hdr_cnt;
  logic [WordW-1:0]  lo_cnt;
  logic [WordW-1:0]  open_cnt;
  logic              open_zero;
  logic              data_last;

  // header field extraction for both layouts
  assign hdr_type = narrow_i ? word_i[15:13] : word_i[31:29];
  assign hdr_op   = narrow_i ? word_i[12:11] : word_i[28:27];
  assign hdr_addr = narrow_i ? {8'd0, word_i[10:5]} : word_i[26:13];
  assign hdr_cnt  = narrow_i ? {27'd0, word_i[4:0]} :
                    (hdr_type == HT_TYPE2) ? {5'd0, word_i[26:0]} : {21'd0, word_i[10:0]};
  assign lo_cnt    = {words_left_r[15:0], 16'd0} | word_i;
  assign open_cnt  = (phase_r == PH_CNT_LO) ? lo_cnt : hdr_cnt;
  assign open_zero = (open_cnt == '0);
  assign data_last = (words_left_r <= 32'd1);

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    words_left_nxt = words_left_r;
    cur_type_nxt   = cur_type_r;
    cur_op_nxt     = cur_op_r;
    cur_addr_nxt   = cur_addr_r;
    prev_addr_nxt  = prev_addr_r;
    prev_valid_nxt = prev_valid_r;
    drop_nxt       = drop_r;
    case (phase_r)
      PH_IDLE: begin
        if (hdr_type == HT_NOOP) begin
          cur_type_nxt   = HT_NOOP;
          cur_op_nxt     = '0;
          cur_addr_nxt   = '0;
          prev_addr_nxt  = '0;
          prev_valid_nxt = 1'b1;
        end else if (hdr_type == HT_TYPE1) begin
          cur_type_nxt   = HT_TYPE1;
          cur_op_nxt     = hdr_op;
          cur_addr_nxt   = hdr_addr;
          prev_addr_nxt  = hdr_addr;
          prev_valid_nxt = 1'b1;
          drop_nxt       = 1'b0;
          if (!open_zero && !end_i) begin
            words_left_nxt = open_cnt;
            phase_nxt      = PH_DATA;
          end
        end else if (hdr_type == HT_TYPE2 && !narrow_i) begin
          // reuse last address; swallow the packet if none is known
          cur_type_nxt = HT_TYPE2;
          cur_op_nxt   = hdr_op;
          cur_addr_nxt = prev_valid_r ? prev_addr_r : '0;
          drop_nxt     = !prev_valid_r && !open_zero && !end_i;
          if (!open_zero && !end_i) begin
            words_left_nxt = open_cnt;
            phase_nxt      = PH_DATA;
          end
        end else if (hdr_type == HT_TYPE2) begin
          cur_type_nxt   = HT_TYPE2;
          cur_op_nxt     = hdr_op;
          cur_addr_nxt   = hdr_addr;
          prev_addr_nxt  = hdr_addr;
          prev_valid_nxt = 1'b1;
          drop_nxt       = 1'b0;
          if (!end_i) begin
            phase_nxt = PH_CNT_HI;
          end
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_CNT_HI: begin
        if (!end_i) begin
          words_left_nxt = word_i;
          phase_nxt      = PH_CNT_LO;
        end
      end
      PH_CNT_LO: begin
        words_left_nxt = '0;
        phase_nxt      = PH_IDLE;
        if (!open_zero && !end_i) begin
          words_left_nxt = open_cnt;
          phase_nxt      = PH_DATA;
        end
      end
      PH_DATA: begin
        if (data_last || !end_i) begin
          if (data_last) begin
            words_left_nxt = '0;
            phase_nxt      = PH_IDLE;
            drop_nxt       = 1'b0;
          end else begin
            words_left_nxt = words_left_r - 32'd1;
          end
        end
      end
      PH_BAD: begin
        phase_nxt = PH_BAD;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // stream end: back to idle, forget the previous packet
    if (end_i) begin
      phase_nxt      = PH_IDLE;
      words_left_nxt = '0;
      drop_nxt       = 1'b0;
      prev_valid_nxt = 1'b0;
    end
  end

  // result for the current word
  always_comb begin
    res_o = '0;
    res_o.kind = KIND_SKIP;
    case (phase_r)
      PH_IDLE: begin
        if (hdr_type == HT_NOOP) begin
          res_o.kind           = KIND_HDR;
          res_o.last_of_packet = 1'b1;
        end else if (hdr_type == HT_TYPE1 || (hdr_type == HT_TYPE2 && !narrow_i)) begin
          res_o.header_kind = cur_type_nxt;
          res_o.operation   = cur_op_nxt;
          res_o.reg_address = cur_addr_nxt;
          if (open_zero) begin
            res_o.kind = (hdr_type == HT_TYPE2 && !prev_valid_r) ? KIND_SKIP : KIND_HDR;
            res_o.last_of_packet = 1'b1;
          end else if (end_i) begin
            res_o.kind          = KIND_TRUNC;
            res_o.payload_count = open_cnt;
            res_o.data          = word_i;
          end else begin
            res_o.kind = (hdr_type == HT_TYPE2 && !prev_valid_r) ? KIND_SKIP : KIND_HDR;
            res_o.payload_count = open_cnt;
          end
        end else if (hdr_type == HT_TYPE2) begin
          res_o.header_kind = cur_type_nxt;
          res_o.operation   = cur_op_nxt;
          res_o.reg_address = cur_addr_nxt;
          res_o.kind        = end_i ? KIND_TRUNC : KIND_SKIP;
          res_o.data        = end_i ? word_i : '0;
        end else begin
          res_o.kind        = KIND_BAD;
          res_o.header_kind = hdr_type;
        end
      end
      PH_CNT_HI: begin
        res_o.header_kind = cur_type_r;
        res_o.operation   = cur_op_r;
        res_o.reg_address = cur_addr_r;
        res_o.kind        = end_i ? KIND_TRUNC : KIND_SKIP;
        res_o.data        = end_i ? word_i : '0;
      end
      PH_CNT_LO: begin
        res_o.header_kind = cur_type_r;
        res_o.operation   = cur_op_r;
        res_o.reg_address = cur_addr_r;
        if (open_zero) begin
          res_o.kind           = KIND_HDR;
          res_o.last_of_packet = 1'b1;
        end else if (end_i) begin
          res_o.kind          = KIND_TRUNC;
          res_o.payload_count = open_cnt;
          res_o.data          = word_i;
        end else begin
          res_o.kind          = KIND_HDR;
          res_o.payload_count = open_cnt;
        end
      end
      PH_DATA: begin
        res_o.header_kind = cur_type_r;
        res_o.operation   = cur_op_r;
        res_o.reg_address = cur_addr_r;
        if (!data_last && end_i) begin
          res_o.kind = KIND_TRUNC;
          res_o.data = word_i;
        end else begin
          res_o.kind           = drop_r ? KIND_SKIP : KIND_DATA;
          res_o.data           = drop_r ? '0 : word_i;
          res_o.last_of_packet = data_last;
        end
      end
      PH_BAD: begin
        res_o.kind = KIND_SKIP;
      end
      default: begin
        res_o.kind = KIND_SKIP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      words_left_r <= '0;
      cur_type_r   <= '0;
      cur_op_r     <= '0;
      cur_addr_r   <= '0;
      prev_addr_r  <= '0;
      prev_valid_r <= 1'b0;
      drop_r       <= 1'b0;
    end else if (step_i) begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
      cur_type_r   <= cur_type_nxt;
      cur_op_r     <= cur_op_nxt;
      cur_addr_r   <= cur_addr_nxt;
      prev_addr_r  <= prev_addr_nxt;
      prev_valid_r <= prev_valid_nxt;
      drop_r       <= drop_nxt;
    end
  end

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && end_i) |=> (phase_r == PH_IDLE && words_left_r == '0 && !prev_valid_r))
    else $error("stream end did not return parser to idle");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (words_left_r != '0))
    else $error("data phase with no words left");

  a_drop_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (phase_r == PH_DATA && cur_addr_r == '0))
    else $error("drop flag outside a swallowed packet");

endmodule

>>> rtl/fpga_config_packet_deframer.sv
// Top level of the configuration packet deframer: input register, parser, output register.
// Depends on cfpd_pkg and cfpd_parser.
// An accepted word passes through the input register and then the output register, which drives out_tvalid.
// Throughput: one word per cycle; out_tready low holds both stages and drops
// in_tready once the input register is full.
// Reset (rst_n low, synchronous): both registers empty, parser idle, wide layout.
module fpga_config_packet_deframer import cfpd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,   // header_layout
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [WordW-1:0]    in_tdata,      // word
  input  logic                in_tlast,      // stream_end
  output logic                out_tvalid,
  input  logic                out_tready,
  // header_kind[2:0], operation[4:3], reg_address[18:5], payload_count[50:19],
  // data[82:51], zero[87:83]
  output logic [OutDataW-1:0] out_tdata,
  output logic [KindW-1:0]    out_tuser,     // kind
  output logic                out_tlast      // last_of_packet
);

  logic             layout_r;
  logic             in_valid_r;
  logic [WordW-1:0] in_word_r;
  logic             in_end_r;
  logic             out_valid_r;
  result_t          out_res_r;
  result_t          res;
  logic             step;
  logic             in_acc;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_acc    = in_tvalid && in_tready;

  cfpd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .word_i   (in_word_r),
    .end_i    (in_end_r),
    .narrow_i (layout_r),
    .res_o    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r    <= 1'b0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        layout_r <= cfg_wr_data;
      end
      in_valid_r  <= in_acc || (in_valid_r && !step);
      out_valid_r <= step || (out_valid_r && !out_tready);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_word_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last_of_packet;
  assign out_tdata  = {5'd0, out_res_r.data, out_res_r.payload_count,
                       out_res_r.reg_address, out_res_r.operation,
                       out_res_r.header_kind};

endmodule
